// ----- hw/rtl/scroll_window_item_layout_macros.svh -----
// assertion helpers for the scroll window layout block
`ifndef SCROLL_WINDOW_ITEM_LAYOUT_MACROS_SVH
`define SCROLL_WINDOW_ITEM_LAYOUT_MACROS_SVH

// property checked on every clock outside reset
`define SWIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define SWIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/swil_pkg.sv -----
package swil_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int MAX_VISIBLE = 64;
  localparam int HW          = 16;  // item height
  localparam int PW          = 27;  // prefix sum / scroll
  localparam int CW          = 11;  // item count, prefix address
  localparam int IW          = 10;  // item index
  localparam int VW          = 7;   // visible count
  localparam int SW          = 29;  // signed scroll accumulator
  localparam int XW          = 30;  // signed compare width

  localparam logic [HW-1:0] DEFAULT_HEIGHT   = 16'd200;
  localparam logic [16:0]   VIEWPORT_DEFAULT = 17'd1920;
  localparam logic [PW-1:0] P27_MAX          = 27'h7FF_FFFF;

  typedef enum logic [1:0] {
    KIND_DELTA  = 2'd0,
    KIND_ABS    = 2'd1,
    KIND_HEIGHT = 2'd2,
    KIND_COUNT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_VIEWPORT   = 2'd0,
    CFG_PAD_TOP    = 2'd1,
    CFG_PAD_BOTTOM = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_PREP,
    ST_REBUILD,
    ST_CLAMP,
    ST_ISSUE,
    ST_CMP,
    ST_NSET,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic [31:0]          generation;
    logic [PW-1:0]        scroll_offset;
    logic [PW-1:0]        max_scroll;
    logic [CW-1:0]        item_count;
    logic [VW-1:0]        visible_count;
    logic                 has_item;
    logic [IW-1:0]        item_index;
    logic signed [27:0]   item_top;
    logic signed [27:0]   item_bottom;
    logic                 last;
  } row_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [HW-1:0] wdata;
    logic [IW-1:0] raddr;
  } h_req_t;

  typedef struct packed {
    logic          we;
    logic [CW-1:0] waddr;
    logic [PW-1:0] wdata;
    logic [CW-1:0] raddr;
  } p_req_t;

endpackage

// ----- hw/rtl/swil_ram.sv -----
module swil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/swil_seq.sv -----
module swil_seq
  import swil_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_kind,
  input  logic [20:0]      in_scroll_delta,
  input  logic [26:0]      in_scroll_abs,
  input  logic [10:0]      in_position,
  input  logic [15:0]      in_height,
  input  logic [10:0]      in_count,
  input  logic [16:0]      vh,
  input  logic [15:0]      pad_top,
  input  logic [15:0]      pad_bottom,
  input  logic             out_free,
  output logic             load,
  output row_t             row,
  output h_req_t           h_req,
  input  logic [HW-1:0]    h_rdata,
  output p_req_t           p_req,
  input  logic [PW-1:0]    p_rdata
);

  state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic signed [SW-1:0] scroll_r, scroll_nxt;
  logic [31:0]          gen_r, gen_nxt;
  logic                 stale_r, stale_nxt;
  logic [PW-1:0]        total_r, total_nxt;
  logic [PW-1:0]        ms_r, ms_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        fill_end_r, fill_end_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic                 pend_r, pend_nxt;
  logic [IW-1:0]        pidx_r, pidx_nxt;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic signed [XW-1:0] vstart_r, vstart_nxt;
  logic signed [XW-1:0] vend_r, vend_nxt;
  logic                 sel_r, sel_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic [CW-1:0]        start_r, start_nxt;
  logic [CW-1:0]        end_r, end_nxt;
  logic [VW-1:0]        n_r, n_nxt;
  logic [VW-1:0]        row_i_r, row_i_nxt;

  logic [CW-1:0]        count_cl;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        lo_cl;
  logic [CW-1:0]        ridx;
  logic                 fill_done;

  assign count_cl  = (in_count > CW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : in_count;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} + {{CW{1'b0}}, 1'b1};
  assign lo_cl     = (lo_r >= count_r) ? count_r - 1'b1 : lo_r;
  assign ridx      = start_r + {{(CW-VW){1'b0}}, row_i_r};
  assign fill_done = (fill_r + 1'b1) == fill_end_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind_t'(in_kind) == KIND_COUNT && count_cl > count_r) begin
            state_nxt = ST_FILL;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_FILL: begin
        if (fill_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (count_r == '0) begin
          state_nxt = ST_EMPTY;
        end else if (stale_r) begin
          state_nxt = ST_REBUILD;
        end else begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_REBUILD: begin
        if (!pend_r && iss_r == count_r) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: state_nxt = ST_ISSUE;
      ST_ISSUE: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_CMP;
        end else if (sel_r) begin
          state_nxt = ST_NSET;
        end
      end
      ST_CMP:    state_nxt = ST_ISSUE;
      ST_NSET:   state_nxt = ST_ROW_RD;
      ST_ROW_RD: state_nxt = ST_ROW_LD;
      ST_ROW_LD: begin
        if (out_free) begin
          state_nxt = ((row_i_r + 1'b1) == n_r) ? ST_IDLE : ST_ROW_RD;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    logic signed [SW:0]   dsum;
    logic [PW:0]          asum;
    logic [PW-1:0]        accn;
    logic signed [PW:0]   msf;
    logic [PW-1:0]        ms;
    logic [PW-1:0]        sc;
    logic signed [XW-1:0] pv;
    logic                 hit;
    logic [CW-1:0]        e;
    logic [CW-1:0]        diff;
    logic signed [27:0]   top;
    logic signed [28:0]   bot;

    count_nxt    = count_r;
    scroll_nxt   = scroll_r;
    gen_nxt      = gen_r;
    stale_nxt    = stale_r;
    total_nxt    = total_r;
    ms_nxt       = ms_r;
    fill_nxt     = fill_r;
    fill_end_nxt = fill_end_r;
    iss_nxt      = iss_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    acc_nxt      = acc_r;
    vstart_nxt   = vstart_r;
    vend_nxt     = vend_r;
    sel_nxt      = sel_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    n_nxt        = n_r;
    row_i_nxt    = row_i_r;

    in_ready     = (state_r == ST_IDLE);
    load         = 1'b0;
    row          = '0;
    h_req.we     = 1'b0;
    h_req.waddr  = in_position[IW-1:0];
    h_req.wdata  = in_height;
    h_req.raddr  = iss_r[IW-1:0];
    p_req.we     = 1'b0;
    p_req.waddr  = '0;
    p_req.wdata  = '0;
    p_req.raddr  = mid_r;

    dsum = '0;
    asum = '0;
    accn = '0;
    msf  = '0;
    ms   = '0;
    sc   = '0;
    pv   = '0;
    hit  = 1'b0;
    e    = '0;
    diff = '0;
    top  = '0;
    bot  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          gen_nxt = gen_r + 32'd1;
          case (kind_t'(in_kind))
            KIND_DELTA: begin
              dsum = {scroll_r[SW-1], scroll_r} + {{(SW-20){in_scroll_delta[20]}},
                     in_scroll_delta};
              // saturate to the 29-bit signed range
              if (dsum[SW] != dsum[SW-1]) begin
                scroll_nxt = dsum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
              end else begin
                scroll_nxt = dsum[SW-1:0];
              end
            end
            KIND_ABS: scroll_nxt = {2'b00, in_scroll_abs};
            KIND_HEIGHT: begin
              if (in_position < count_r && in_height != '0) begin
                h_req.we  = 1'b1;
                stale_nxt = 1'b1;
              end
            end
            KIND_COUNT: begin
              if (count_cl > count_r) begin
                fill_nxt     = count_r;
                fill_end_nxt = count_cl;
                stale_nxt    = 1'b1;
              end else if (count_cl < count_r) begin
                count_nxt = count_cl;
                stale_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        h_req.we    = 1'b1;
        h_req.waddr = fill_r[IW-1:0];
        h_req.wdata = DEFAULT_HEIGHT;
        fill_nxt    = fill_r + 1'b1;
        if (fill_done) begin
          count_nxt = fill_end_r;
        end
      end
      ST_PREP: begin
        iss_nxt  = '0;
        pend_nxt = 1'b0;
        acc_nxt  = '0;
      end
      ST_REBUILD: begin
        h_req.raddr = iss_r[IW-1:0];
        pend_nxt    = iss_r < count_r;
        pidx_nxt    = iss_r[IW-1:0];
        if (iss_r < count_r) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (pend_r) begin
          asum        = {1'b0, acc_r} + {{(PW+1-HW){1'b0}}, h_rdata};
          accn        = asum[PW] ? P27_MAX : asum[PW-1:0];
          acc_nxt     = accn;
          p_req.we    = 1'b1;
          p_req.waddr = {1'b0, pidx_r} + 1'b1;
          p_req.wdata = accn;
        end else if (iss_r == '0) begin
          // top of item zero
          p_req.we = 1'b1;
        end
        if (!pend_r && iss_r == count_r) begin
          total_nxt = acc_r;
          stale_nxt = 1'b0;
        end
      end
      ST_CLAMP: begin
        msf = $signed({1'b0, total_r}) - $signed({{(PW-16){1'b0}}, vh});
        ms  = msf[PW] ? '0 : msf[PW-1:0];
        if (scroll_r[SW-1]) begin
          sc = '0;
        end else if (scroll_r > $signed({2'b00, ms})) begin
          sc = ms;
        end else begin
          sc = scroll_r[PW-1:0];
        end
        scroll_nxt = {2'b00, sc};
        ms_nxt     = ms;
        vstart_nxt = $signed({3'b000, sc}) - $signed({{(XW-16){1'b0}}, pad_top});
        vend_nxt   = $signed({3'b000, sc}) + $signed({{(XW-17){1'b0}}, vh})
                   + $signed({{(XW-16){1'b0}}, pad_bottom});
        sel_nxt    = 1'b0;
        lo_nxt     = '0;
        hi_nxt     = count_r;
      end
      ST_ISSUE: begin
        if (lo_r < hi_r) begin
          mid_nxt     = mid_sum[CW:1];
          p_req.raddr = mid_sum[CW:1];
        end else if (!sel_r) begin
          start_nxt = lo_cl;
          sel_nxt   = 1'b1;
          lo_nxt    = '0;
          hi_nxt    = count_r;
        end else begin
          // one extra row past the last covered item
          e = lo_cl;
          if (e < count_r - 1'b1) begin
            e = e + 1'b1;
          end
          end_nxt = e;
        end
      end
      ST_CMP: begin
        p_req.raddr = mid_r;
        pv  = $signed({3'b000, p_rdata});
        hit = sel_r ? (pv < vend_r) : (pv <= vstart_r);
        if (hit) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r - 1'b1;
        end
      end
      ST_NSET: begin
        diff      = end_r - start_r + 1'b1;
        n_nxt     = (diff > CW'(MAX_VISIBLE)) ? VW'(MAX_VISIBLE) : diff[VW-1:0];
        row_i_nxt = '0;
      end
      ST_ROW_RD: begin
        h_req.raddr = ridx[IW-1:0];
        p_req.raddr = ridx;
      end
      ST_ROW_LD: begin
        h_req.raddr = ridx[IW-1:0];
        p_req.raddr = ridx;
        top = $signed({1'b0, p_rdata}) - $signed({1'b0, scroll_r[PW-1:0]});
        bot = {top[27], top} + $signed({13'b0, h_rdata});
        row.generation    = gen_r;
        row.scroll_offset = scroll_r[PW-1:0];
        row.max_scroll    = ms_r;
        row.item_count    = count_r;
        row.visible_count = n_r;
        row.has_item      = 1'b1;
        row.item_index    = ridx[IW-1:0];
        row.item_top      = top;
        row.item_bottom   = (bot > $signed({2'b00, P27_MAX})) ? $signed({1'b0, P27_MAX})
                                                              : bot[27:0];
        row.last          = (row_i_r + 1'b1) == n_r;
        if (out_free) begin
          load      = 1'b1;
          row_i_nxt = row_i_r + 1'b1;
        end
      end
      ST_EMPTY: begin
        row.generation = gen_r;
        row.last       = 1'b1;
        load           = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      scroll_r <= '0;
      gen_r    <= '0;
      stale_r  <= 1'b1;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      scroll_r <= scroll_nxt;
      gen_r    <= gen_nxt;
      stale_r  <= stale_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    ms_r       <= ms_nxt;
    fill_r     <= fill_nxt;
    fill_end_r <= fill_end_nxt;
    iss_r      <= iss_nxt;
    pidx_r     <= pidx_nxt;
    acc_r      <= acc_nxt;
    vstart_r   <= vstart_nxt;
    vend_r     <= vend_nxt;
    sel_r      <= sel_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    n_r        <= n_nxt;
    row_i_r    <= row_i_nxt;
  end

endmodule

// ----- hw/rtl/scroll_window_item_layout.sv -----
// Visible-range layout for a virtualized list of up to 1024 variable-height
// items. Each input word (scroll delta, absolute scroll, item height or item
// count) yields one snapshot: one result word per visible row, up to 64, or a
// single row-less word when the list is empty. Heights
// live in a 1024-entry RAM and item tops in a 1025-entry prefix-sum RAM; a
// word is taken only while the sequencer is idle. Per input word: a count
// increase writes one new height per cycle; a changed height or count
// triggers a prefix rebuild through the height RAM read port; then come
// the clamp and two binary searches over the prefix RAM; each row is then
// read from both RAMs and loaded into the output register, waiting while
// the output is stalled. Results sit in an output register, so a new input
// word can be taken while the last word of a snapshot waits. No memory
// clearing is needed after reset.
module scroll_window_item_layout
  import swil_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [20:0]         in_scroll_delta,
  input  logic [26:0]         in_scroll_abs,
  input  logic [10:0]         in_position,
  input  logic [15:0]         in_height,
  input  logic [10:0]         in_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_generation,
  output logic [26:0]         out_scroll_offset,
  output logic [26:0]         out_max_scroll,
  output logic [10:0]         out_item_count,
  output logic [6:0]          out_visible_count,
  output logic                out_has_item,
  output logic [9:0]          out_item_index,
  output logic signed [27:0]  out_item_top,
  output logic signed [27:0]  out_item_bottom,
  output logic                out_last
);

`include "scroll_window_item_layout_macros.svh"

  logic [15:0]   viewport_r, pad_top_r, pad_bottom_r;
  logic [16:0]   vh;
  logic          out_valid_r;
  row_t          row_r;
  row_t          row;
  logic          load;
  logic          out_free;
  h_req_t        h_req;
  p_req_t        p_req;
  logic [HW-1:0] h_rdata;
  logic [PW-1:0] p_rdata;

  assign vh       = (viewport_r == '0) ? VIEWPORT_DEFAULT : {1'b0, viewport_r};
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viewport_r   <= 16'd1920;
      pad_top_r    <= '0;
      pad_bottom_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VIEWPORT:   viewport_r   <= cfg_wdata;
        CFG_PAD_TOP:    pad_top_r    <= cfg_wdata;
        CFG_PAD_BOTTOM: pad_bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  swil_ram #(.WIDTH(HW), .DEPTH(MAX_ITEMS)) u_height_ram (
    .clk   (clk),
    .we    (h_req.we),
    .waddr (h_req.waddr),
    .wdata (h_req.wdata),
    .raddr (h_req.raddr),
    .rdata (h_rdata)
  );

  swil_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS + 1)) u_prefix_ram (
    .clk   (clk),
    .we    (p_req.we),
    .waddr (p_req.waddr),
    .wdata (p_req.wdata),
    .raddr (p_req.raddr),
    .rdata (p_rdata)
  );

  swil_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_scroll_delta (in_scroll_delta),
    .in_scroll_abs   (in_scroll_abs),
    .in_position     (in_position),
    .in_height       (in_height),
    .in_count        (in_count),
    .vh              (vh),
    .pad_top         (pad_top_r),
    .pad_bottom      (pad_bottom_r),
    .out_free        (out_free),
    .load            (load),
    .row             (row),
    .h_req           (h_req),
    .h_rdata         (h_rdata),
    .p_req           (p_req),
    .p_rdata         (p_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r <= row;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_generation    = row_r.generation;
  assign out_scroll_offset = row_r.scroll_offset;
  assign out_max_scroll    = row_r.max_scroll;
  assign out_item_count    = row_r.item_count;
  assign out_visible_count = row_r.visible_count;
  assign out_has_item      = row_r.has_item;
  assign out_item_index    = row_r.item_index;
  assign out_item_top      = row_r.item_top;
  assign out_item_bottom   = row_r.item_bottom;
  assign out_last          = row_r.last;

  `SWIL_ASSERT(a_empty_is_last, out_valid && !out_has_item |-> out_last, "row-less word not last")
  `SWIL_ASSERT(a_row_in_range, out_valid && out_has_item |-> (out_visible_count != 7'd0 && out_item_index < out_item_count), "row outside item range")
  `SWIL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "word taken while busy")

endmodule

// ----- tb/tb_scroll_window_item_layout.sv -----
`timescale 1ns / 100ps

module tb_scroll_window_item_layout;
  import swil_pkg::*;

  localparam int  LIMIT_CYCLES = 4000000;
  localparam int  HOLD_CYCLES  = 6000;
  localparam int  SETTLE       = 1400;
  localparam longint SCROLL_HI = 268435455;
  localparam longint SCROLL_LO = -268435456;

  typedef struct {
    kind_t       kind;
    logic [20:0] delta;
    logic [26:0] abs_pos;
    logic [10:0] position;
    logic [15:0] height;
    logic [10:0] count;
  } word_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [1:0] in_kind;
  logic [20:0] in_scroll_delta;
  logic [26:0] in_scroll_abs;
  logic [10:0] in_position;
  logic [15:0] in_height;
  logic [10:0] in_count;
  logic out_valid, out_ready;
  logic [31:0] out_generation;
  logic [26:0] out_scroll_offset, out_max_scroll;
  logic [10:0] out_item_count;
  logic [6:0] out_visible_count;
  logic out_has_item;
  logic [9:0] out_item_index;
  logic signed [27:0] out_item_top, out_item_bottom;
  logic out_last;

  scroll_window_item_layout DUT (.*);

  // layout state mirror
  logic [15:0] heights [MAX_ITEMS];
  longint      tops [MAX_ITEMS+1];
  int          num_items;
  longint      scroll_pos;
  logic [31:0] snap_gen;
  bit          tops_stale;
  int          viewport, pad_above, pad_below;

  word_t pending_words[$];
  row_t  expected_rows[$];
  int    tx_idle_pct, rx_idle_pct;
  int    words_taken, mismatches;
  int    cycles;
  bit    hold_done;
  int    hold_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void push_row(int n, bit has, int idx, longint top, longint bot,
                                   bit last);
    row_t r;
    r.generation    = snap_gen;
    r.scroll_offset = (num_items == 0) ? '0 : scroll_pos[26:0];
    r.max_scroll    = '0;
    r.item_count    = num_items[10:0];
    r.visible_count = n[6:0];
    r.has_item      = has;
    r.item_index    = idx[9:0];
    r.item_top      = top[27:0];
    r.item_bottom   = bot[27:0];
    r.last          = last;
    expected_rows.push_back(r);
  endfunction

  function automatic void layout_step(word_t w);
    longint s, vh, total, ms, vstart, vend, top, bot;
    int c, ub, lb, first, final_idx, n;
    case (w.kind)
      KIND_DELTA: begin
        s = scroll_pos + longint'($signed(w.delta));
        if (s > SCROLL_HI) s = SCROLL_HI;
        if (s < SCROLL_LO) s = SCROLL_LO;
        scroll_pos = s;
      end
      KIND_ABS: scroll_pos = w.abs_pos;
      KIND_HEIGHT: begin
        if (w.position < num_items && w.height != 0 && heights[w.position] != w.height) begin
          heights[w.position] = w.height;
          tops_stale = 1;
        end
      end
      default: begin
        c = (w.count > MAX_ITEMS) ? MAX_ITEMS : w.count;
        if (c != num_items) begin
          for (int i = num_items; i < c; i++) heights[i] = DEFAULT_HEIGHT;
          num_items = c;
          tops_stale = 1;
        end
      end
    endcase
    snap_gen = snap_gen + 1;
    if (num_items == 0) begin
      push_row(0, 0, 0, 0, 0, 1);
      return;
    end
    if (tops_stale) begin
      tops[0] = 0;
      for (int i = 0; i < num_items; i++) begin
        tops[i+1] = tops[i] + heights[i];
        if (tops[i+1] > 134217727) tops[i+1] = 134217727;
      end
      tops_stale = 0;
    end
    vh = (viewport != 0) ? viewport : 1920;
    total = tops[num_items];
    ms = total - vh;
    if (ms < 0) ms = 0;
    if (scroll_pos < 0) scroll_pos = 0;
    if (scroll_pos > ms) scroll_pos = ms;
    vstart = scroll_pos - pad_above;
    vend = scroll_pos + vh + pad_below;
    ub = 0;
    lb = 0;
    for (int i = 0; i <= num_items; i++) begin
      if (tops[i] <= vstart) ub = i + 1;
      if (tops[i] < vend) lb = i + 1;
    end
    first = ub ? ub - 1 : 0;
    if (first >= num_items) first = num_items - 1;
    final_idx = lb ? lb - 1 : 0;
    if (final_idx >= num_items) final_idx = num_items - 1;
    if (final_idx + 1 <= num_items - 1) final_idx++;
    n = final_idx - first + 1;
    if (n < 0) n = 0;
    if (n > MAX_VISIBLE) n = MAX_VISIBLE;
    if (n == 0) begin
      push_row(0, 0, 0, 0, 0, 1);
      expected_rows[$].max_scroll = ms[26:0];
      return;
    end
    for (int i = 0; i < n; i++) begin
      top = tops[first+i] - scroll_pos;
      bot = top + heights[first+i];
      if (bot > 134217727) bot = 134217727;
      push_row(n, 1, first + i, top, bot, i == n - 1);
      expected_rows[$].max_scroll = ms[26:0];
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        word_t w;
        w = pending_words.pop_front();
        in_valid        <= 1;
        in_kind         <= w.kind;
        in_scroll_delta <= w.delta;
        in_scroll_abs   <= w.abs_pos;
        in_position     <= w.position;
        in_height       <= w.height;
        in_count        <= w.count;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver, with one long hold-off while words keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (!hold_done && words_taken == 120) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        word_t w;
        w.kind = kind_t'(in_kind);
        w.delta = in_scroll_delta;
        w.abs_pos = in_scroll_abs;
        w.position = in_position;
        w.height = in_height;
        w.count = in_count;
        layout_step(w);
        words_taken <= words_taken + 1;
      end
      if (out_valid && out_ready) begin
        row_t got, want;
        got = '{out_generation, out_scroll_offset, out_max_scroll, out_item_count,
                out_visible_count, out_has_item, out_item_index, out_item_top,
                out_item_bottom, out_last};
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", got);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
    end
  end

  function automatic word_t mk(kind_t k, int d = 0, int a = 0, int p = 0, int h = 0,
                               int c = 0);
    word_t w;
    w.kind = k;
    w.delta = d[20:0];
    w.abs_pos = a[26:0];
    w.position = p[10:0];
    w.height = h[15:0];
    w.count = c[10:0];
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w = mk(kind_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom, $urandom);
    case (w.kind)
      KIND_DELTA:
        if ($urandom_range(2) != 0) w.delta = $urandom_range(8000) - 4000;
      KIND_ABS:
        if ($urandom_range(2) != 0) w.abs_pos = $urandom_range(20000);
      KIND_HEIGHT: begin
        if ($urandom_range(3) != 0) w.position = $urandom_range(num_items + 2);
        case ($urandom_range(5))
          0: w.height = 0;
          1, 2: w.height = $urandom_range(1, 600);
          3: w.height = $urandom_range(1, 30);
          default: ;
        endcase
      end
      default:
        case ($urandom_range(9))
          0: w.count = $urandom_range(1024);
          1: w.count = $urandom_range(2047);
          2: w.count = 0;
          default: w.count = $urandom_range(1, 80);
        endcase
    endcase
    return w;
  endfunction

  task automatic wait_drained();
    forever begin
      @(posedge clk);
      #1;
      if (pending_words.size() == 0 && !in_valid && expected_rows.size() == 0) break;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    case (idx)
      CFG_VIEWPORT:  viewport = val[15:0];
      CFG_PAD_TOP:   pad_above = val[15:0];
      default:       pad_below = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) pending_words.push_back(rand_word());
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = CFG_VIEWPORT; cfg_wdata = 0;
    in_kind = KIND_DELTA; in_scroll_delta = 0; in_scroll_abs = 0;
    in_position = 0; in_height = 0; in_count = 0;
    num_items = 0; scroll_pos = 0; snap_gen = 0; tops_stale = 1;
    viewport = 1920; pad_above = 0; pad_below = 0;
    words_taken = 0; mismatches = 0; cycles = 0;
    tx_idle_pct = 36; rx_idle_pct = 55;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: empty list, scroll saturation, growth, ignored updates, clamps
    pending_words.push_back(mk(KIND_DELTA, -1048576));
    pending_words.push_back(mk(KIND_DELTA, -1048576));
    pending_words.push_back(mk(KIND_ABS, 0, 134217727));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 1));
    pending_words.push_back(mk(KIND_HEIGHT, 0, 0, 0, 65535));
    pending_words.push_back(mk(KIND_HEIGHT, 0, 0, 1, 77));
    pending_words.push_back(mk(KIND_HEIGHT, 0, 0, 0, 0));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 12));
    pending_words.push_back(mk(KIND_HEIGHT, 0, 0, 11, 1));
    pending_words.push_back(mk(KIND_HEIGHT, 0, 0, 2047, 500));
    pending_words.push_back(mk(KIND_DELTA, 1048575));
    pending_words.push_back(mk(KIND_DELTA, -1));
    pending_words.push_back(mk(KIND_ABS, 0, 300));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 2047));
    pending_words.push_back(mk(KIND_ABS, 0, 134217727));
    pending_words.push_back(mk(KIND_DELTA, -1048576));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 1024));
    pending_words.push_back(mk(KIND_HEIGHT, 0, 0, 1023, 65535));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 5));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 9));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(KIND_DELTA, 1048575));
    pending_words.push_back(mk(KIND_COUNT, 0, 0, 0, 0, 3));
    wait_drained();

    tx_idle_pct = 36; rx_idle_pct = 55;
    write_reg(CFG_VIEWPORT, 0);
    write_reg(CFG_PAD_TOP, 300);
    write_reg(CFG_PAD_BOTTOM, 65535);
    random_words(90);
    wait_drained();

    tx_idle_pct = 55; rx_idle_pct = 36;
    write_reg(CFG_VIEWPORT, 1);
    write_reg(CFG_PAD_TOP, 65535);
    write_reg(CFG_PAD_BOTTOM, 0);
    random_words(90);
    wait_drained();

    tx_idle_pct = 0; rx_idle_pct = 0;
    write_reg(CFG_VIEWPORT, 65535);
    write_reg(CFG_PAD_TOP, 0);
    write_reg(CFG_PAD_BOTTOM, 150);
    random_words(40);
    wait_drained();
    write_reg(CFG_VIEWPORT, 700);
    random_words(40);
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- scroll_window_item_layout.f -----
+incdir+hw/rtl
hw/rtl/swil_pkg.sv
hw/rtl/swil_ram.sv
hw/rtl/swil_seq.sv
hw/rtl/scroll_window_item_layout.sv
tb/tb_scroll_window_item_layout.sv
